// ----- rtl/apps_pkg.sv -----
// Shared types and codes for the aging priority process scheduler.
// Holds the sequencer state enum and the operation, status, outcome and mode codes.
// No dependencies.
package apps_pkg;

  // Operation codes of one input word
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_EXIT   = 3'd2;
  localparam logic [2:0] OP_KILL   = 3'd3;
  localparam logic [2:0] OP_PRIO   = 3'd4;

  // Slot status codes
  localparam logic [1:0] ST_TERM  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Outcome codes
  localparam logic [1:0] OUT_OK        = 2'd0;
  localparam logic [1:0] OUT_NOT_ALIVE = 2'd1;
  localparam logic [1:0] OUT_FULL      = 2'd2;

  // Scheduling modes
  localparam logic MODE_RR  = 1'b0;
  localparam logic MODE_PRI = 1'b1;

  // Base priority width
  localparam int BASE_W = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MODIFY,
    S_SCHED,
    S_SCAN,
    S_SCAN_END,
    S_SW_RD_OLD,
    S_SW_WR_OLD,
    S_SW_RD_NEW,
    S_SW_WR_NEW,
    S_DONE
  } state_t;

endpackage

// ----- rtl/aging_priority_process_scheduler_top.sv -----
// Top level of the aging priority process scheduler: slot table memory and sequencer.
// Depends on apps_pkg for the state enum and the operation, status and outcome codes.
//
// The block keeps a table of SLOTS process slots (status, age, base priority) in a
// single-port-write, registered-read memory, plus the running slot, the highest slot
// in use and a live count. Each request word is one operation: tick, create, exit,
// kill or set priority; each yields exactly one response word. The sequencer walks
// the table through one memory read per cycle, pipelined with the matching
// read-modify-write. A priority schedule or a create scans slots 0..highest_slot;
// round robin scans only the slots above the running one.
// The request side stalls while an operation is in progress; the next request is
// taken while the previous response still sits in the output register. Table
// entries not yet written since reset read as their reset values through one valid
// flop per slot, so no clearing pass is needed after reset.
module aging_priority_process_scheduler_top #(
  parameter int SLOTS    = 32,
  parameter int AGE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic       cfg_data,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] operation,
  input  logic [4:0] target_slot,
  input  logic [3:0] new_priority,
  // response channel
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [4:0] running_now,
  output logic [4:0] created_slot,
  output logic       switched,
  output logic [1:0] outcome
);

  localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int LIVE_W = $clog2(SLOTS + 1);
  localparam int TGT_W  = (SLOT_W > 5) ? SLOT_W + 1 : 6;
  localparam int BW     = apps_pkg::BASE_W;
  localparam int ENT_W  = 2 + AGE_BITS + BW;
  localparam int SUM_W  = AGE_BITS + 1;

  // Sequencer
  apps_pkg::state_t state, state_next;

  // Latched request
  logic [2:0]        op,   op_next;
  logic [TGT_W-1:0]  tgt,  tgt_next;
  logic [BW-1:0]     prio, prio_next;

  // Scheduler state
  logic [SLOT_W-1:0] running, running_next;
  logic [SLOT_W-1:0] highest, highest_next;
  logic [LIVE_W-1:0] live,    live_next;
  logic              sched_mode;

  // Per-operation working registers
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic [SLOT_W-1:0] created,   created_next;
  logic [1:0]        result,    result_next;
  logic              sw,        sw_next;
  logic              crt,       crt_next;
  logic              found,     found_next;
  logic [SLOT_W-1:0] best_idx,  best_idx_next;
  logic [SUM_W-1:0]  best,      best_next;
  logic [SLOT_W-1:0] scan_idx,  scan_idx_next;
  logic              scan_run,  scan_run_next;
  logic              p_valid,   p_valid_next;

  // Response load
  logic              rsp_load;

  // Slot table memory
  logic [ENT_W-1:0]  mem [SLOTS];
  logic [SLOTS-1:0]  vld;
  logic [SLOT_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ENT_W-1:0]  mem_wdata;
  logic [ENT_W-1:0]  rd_data;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_addr_q;

  // Decoded read entry
  logic [ENT_W-1:0]    ent;
  logic [1:0]          ent_status;
  logic [AGE_BITS-1:0] ent_age;
  logic [BW-1:0]       ent_base;
  logic                ent_alive;
  logic [AGE_BITS-1:0] ent_age_inc;
  logic [SUM_W-1:0]    ent_sum;

  logic                tgt_oor;
  logic [SLOT_W-1:0]   tgt_idx;
  logic                scan_pri;
  logic                scan_rr;
  logic                table_full;

  // An entry never written since reset reads as its reset value
  assign ent = rd_vld ? rd_data :
               (rd_addr_q == '0) ? {apps_pkg::ST_EXEC, {AGE_BITS{1'b0}}, BW'(1)}
                                 : {apps_pkg::ST_TERM, {AGE_BITS{1'b0}}, BW'(0)};

  assign ent_status  = ent[ENT_W-1 -: 2];
  assign ent_age     = ent[AGE_BITS+BW-1:BW];
  assign ent_base    = ent[BW-1:0];
  assign ent_alive   = (ent_status == apps_pkg::ST_READY) ||
                       (ent_status == apps_pkg::ST_EXEC);
  assign ent_age_inc = (ent_age == {AGE_BITS{1'b1}}) ? ent_age : ent_age + 1'b1;
  assign ent_sum     = {1'b0, ent_age} + SUM_W'(ent_base);

  assign tgt_oor    = (tgt >= TGT_W'(SLOTS));
  assign tgt_idx    = tgt[SLOT_W-1:0];
  assign scan_pri   = (op != apps_pkg::OP_CREATE) && (sched_mode == apps_pkg::MODE_PRI);
  assign scan_rr    = (op != apps_pkg::OP_CREATE) && (sched_mode == apps_pkg::MODE_RR);
  assign table_full = !found && (highest == SLOT_W'(SLOTS - 1));

  assign req_stall = (state != apps_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      apps_pkg::S_IDLE: begin
        if (req_valid) state_next = apps_pkg::S_DISPATCH;
      end
      apps_pkg::S_DISPATCH: begin
        case (op)
          apps_pkg::OP_TICK:   state_next = apps_pkg::S_SCHED;
          apps_pkg::OP_CREATE: state_next = apps_pkg::S_SCAN;
          apps_pkg::OP_EXIT:   state_next = apps_pkg::S_MODIFY;
          apps_pkg::OP_KILL:   state_next = tgt_oor ? apps_pkg::S_DONE : apps_pkg::S_MODIFY;
          apps_pkg::OP_PRIO:   state_next = apps_pkg::S_MODIFY;
          default:             state_next = apps_pkg::S_DONE;
        endcase
      end
      apps_pkg::S_MODIFY: begin
        case (op)
          apps_pkg::OP_EXIT: state_next = apps_pkg::S_SCHED;
          apps_pkg::OP_KILL: state_next = ent_alive ? apps_pkg::S_SCHED : apps_pkg::S_DONE;
          default:           state_next = apps_pkg::S_DONE;
        endcase
      end
      apps_pkg::S_SCHED: begin
        if (live <= LIVE_W'(1))                   state_next = apps_pkg::S_DONE;
        else if (sched_mode == apps_pkg::MODE_PRI) state_next = apps_pkg::S_SCAN;
        else if (running < highest)               state_next = apps_pkg::S_SCAN;
        else                                      state_next = apps_pkg::S_SW_RD_OLD;
      end
      apps_pkg::S_SCAN: begin
        if (!scan_run && p_valid) state_next = apps_pkg::S_SCAN_END;
      end
      apps_pkg::S_SCAN_END: begin
        if (op == apps_pkg::OP_CREATE && table_full) state_next = apps_pkg::S_DONE;
        else                                         state_next = apps_pkg::S_SW_RD_OLD;
      end
      apps_pkg::S_SW_RD_OLD: state_next = apps_pkg::S_SW_WR_OLD;
      apps_pkg::S_SW_WR_OLD: state_next = apps_pkg::S_SW_RD_NEW;
      apps_pkg::S_SW_RD_NEW: state_next = apps_pkg::S_SW_WR_NEW;
      apps_pkg::S_SW_WR_NEW: state_next = apps_pkg::S_DONE;
      apps_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = apps_pkg::S_IDLE;
      end
      default: state_next = apps_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_next        = op;
    tgt_next       = tgt;
    prio_next      = prio;
    running_next   = running;
    highest_next   = highest;
    live_next      = live;
    next_slot_next = next_slot;
    created_next   = created;
    result_next    = result;
    sw_next        = sw;
    crt_next       = crt;
    found_next     = found;
    best_idx_next  = best_idx;
    best_next      = best;
    scan_idx_next  = scan_idx;
    scan_run_next  = scan_run;
    p_valid_next   = 1'b0;
    mem_raddr      = running;
    mem_we         = 1'b0;
    mem_wdata      = ent;
    rsp_load       = 1'b0;

    case (state)
      apps_pkg::S_IDLE: begin
        // latch the request word and clear per-operation results
        if (req_valid) begin
          op_next      = operation;
          tgt_next     = TGT_W'(target_slot);
          prio_next    = new_priority;
          created_next = '0;
          result_next  = apps_pkg::OUT_OK;
          sw_next      = 1'b0;
          crt_next     = 1'b0;
        end
      end
      apps_pkg::S_DISPATCH: begin
        case (op)
          apps_pkg::OP_CREATE: begin
            scan_idx_next = '0;
            scan_run_next = 1'b1;
            found_next    = 1'b0;
          end
          apps_pkg::OP_KILL: begin
            if (tgt_oor) result_next = apps_pkg::OUT_NOT_ALIVE;
            mem_raddr = tgt_idx;
          end
          default: mem_raddr = running;
        endcase
      end
      apps_pkg::S_MODIFY: begin
        case (op)
          apps_pkg::OP_EXIT: begin
            mem_we    = 1'b1;
            mem_wdata = {apps_pkg::ST_TERM, ent_age, ent_base};
            if (live > LIVE_W'(1)) live_next = live - 1'b1;
          end
          apps_pkg::OP_KILL: begin
            if (ent_alive) begin
              mem_we    = 1'b1;
              mem_wdata = {apps_pkg::ST_TERM, ent_age, ent_base};
              if (live > LIVE_W'(1)) live_next = live - 1'b1;
            end else begin
              result_next = apps_pkg::OUT_NOT_ALIVE;
            end
          end
          apps_pkg::OP_PRIO: begin
            mem_we    = 1'b1;
            mem_wdata = {ent_status, {AGE_BITS{1'b0}}, prio};
          end
          default: mem_we = 1'b0;
        endcase
      end
      apps_pkg::S_SCHED: begin
        // priority scans every used slot, round robin those above the running one
        found_next = 1'b0;
        best_next  = '0;
        if (live > LIVE_W'(1)) begin
          if (sched_mode == apps_pkg::MODE_PRI) begin
            scan_idx_next = '0;
            scan_run_next = 1'b1;
          end else if (running < highest) begin
            scan_idx_next = running + 1'b1;
            scan_run_next = 1'b1;
          end else begin
            next_slot_next = '0;
            sw_next        = 1'b1;
          end
        end
      end
      apps_pkg::S_SCAN: begin
        // issue one read per cycle, process the word read last cycle
        if (scan_run) begin
          mem_raddr    = scan_idx;
          p_valid_next = 1'b1;
          if (scan_idx == highest) scan_run_next = 1'b0;
          else                     scan_idx_next = scan_idx + 1'b1;
        end
        if (p_valid) begin
          if (scan_pri) begin
            mem_we    = 1'b1;
            mem_wdata = {ent_status, ent_age_inc, ent_base};
            if (ent_alive && (!found || ent_sum > best)) begin
              found_next    = 1'b1;
              best_next     = ent_sum;
              best_idx_next = rd_addr_q;
            end
          end else if (scan_rr) begin
            if (ent_alive && !found) begin
              found_next    = 1'b1;
              best_idx_next = rd_addr_q;
            end
          end else begin
            if (ent_status == apps_pkg::ST_TERM && !found) begin
              found_next    = 1'b1;
              best_idx_next = rd_addr_q;
            end
          end
        end
      end
      apps_pkg::S_SCAN_END: begin
        if (op == apps_pkg::OP_CREATE) begin
          if (found) begin
            next_slot_next = best_idx;
            created_next   = best_idx;
            crt_next       = 1'b1;
            if (live < LIVE_W'(SLOTS)) live_next = live + 1'b1;
          end else if (!table_full) begin
            highest_next   = highest + 1'b1;
            next_slot_next = highest + 1'b1;
            created_next   = highest + 1'b1;
            crt_next       = 1'b1;
            if (live < LIVE_W'(SLOTS)) live_next = live + 1'b1;
          end else begin
            result_next = apps_pkg::OUT_FULL;
          end
        end else begin
          next_slot_next = found ? best_idx : '0;
          sw_next        = 1'b1;
        end
      end
      apps_pkg::S_SW_RD_OLD: mem_raddr = running;
      apps_pkg::S_SW_WR_OLD: begin
        // old running slot drops to ready unless it was terminated
        mem_we    = 1'b1;
        mem_wdata = {(ent_status == apps_pkg::ST_TERM) ? apps_pkg::ST_TERM
                                                       : apps_pkg::ST_READY,
                     ent_age, ent_base};
      end
      apps_pkg::S_SW_RD_NEW: mem_raddr = next_slot;
      apps_pkg::S_SW_WR_NEW: begin
        mem_we       = 1'b1;
        mem_wdata    = {apps_pkg::ST_EXEC, {AGE_BITS{1'b0}}, crt ? BW'(0) : ent_base};
        running_next = next_slot;
      end
      apps_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) rsp_load = 1'b1;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= apps_pkg::S_IDLE;
      running    <= '0;
      highest    <= '0;
      live       <= LIVE_W'(1);
      sched_mode <= apps_pkg::MODE_PRI;
      scan_run   <= 1'b0;
      p_valid    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      running  <= running_next;
      highest  <= highest_next;
      live     <= live_next;
      scan_run <= scan_run_next;
      p_valid  <= p_valid_next;
      if (cfg_write) sched_mode <= cfg_data;
      if (rsp_load)        rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op        <= op_next;
    tgt       <= tgt_next;
    prio      <= prio_next;
    next_slot <= next_slot_next;
    created   <= created_next;
    result    <= result_next;
    sw        <= sw_next;
    crt       <= crt_next;
    found     <= found_next;
    best_idx  <= best_idx_next;
    best      <= best_next;
    scan_idx  <= scan_idx_next;
    if (rsp_load) begin
      running_now  <= 5'(running);
      created_slot <= 5'(created);
      switched     <= sw;
      outcome      <= result;
    end
  end

  // Slot table: write at the address last read, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[rd_addr_q] <= mem_wdata;
    rd_data   <= mem[mem_raddr];
    rd_addr_q <= mem_raddr;
  end

  // Written flags per slot
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) vld[rd_addr_q] <= 1'b1;
      rd_vld <= vld[mem_raddr];
    end
  end

endmodule
